/* rtl/core/counting_prefix_trie_defines.svh */
// assertion macros for the checker of the counting prefix trie
// no dependencies; included by files that hold concurrent assertions
`ifndef COUNTING_PREFIX_TRIE_DEFINES_SVH
`define COUNTING_PREFIX_TRIE_DEFINES_SVH

// same-cycle implication
`define CPT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("counting prefix trie check failed");

// next-cycle implication
`define CPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("counting prefix trie check failed");

`endif

/* rtl/core/cpt_pkg.sv */
// types, constants and helper functions of the counting prefix trie
// no dependencies; used by counting_prefix_trie and cpt_checker
`default_nettype none

package cpt_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int COUNT_BITS    = 16;

   localparam int NODE_W   = $clog2(NODE_COUNT);
   localparam int FREE_W   = NODE_W + 1;
   localparam int LINK_W   = NODE_W;
   localparam int ROW_W    = ALPHABET_SIZE * LINK_W;
   localparam int LETTER_W = 5;
   localparam int OUT_W    = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_EQUAL  = 2'd1,
      CMD_PREFIX = 2'd2,
      CMD_ERASE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_POOL_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_COUNT
   } state_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] end_cnt;
      logic [COUNT_BITS-1:0] pfx_cnt;
   } count_row_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_dec(input logic [COUNT_BITS-1:0] v);
      return (v == '0) ? v : v - 1'b1;
   endfunction

   function automatic logic [OUT_W-1:0] clip_count(input logic [COUNT_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/counting_prefix_trie.sv */
// counting prefix trie: node pool of child links and end/prefix counts
// in two synchronous memories; depends on cpt_pkg
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------
//   req     | in  | req_tvalid/tready    | tdata letter, tuser command+has_letter,
//           |     |                      | tlast last_letter
//   rsp     | out | rsp_tvalid/tready    | tdata count, tuser status
//
// steps: a letter goes through the child-table read and then the count read; after
//   a letter inside a word the next item is taken in the count update cycle, or in
//   idle for a query, which skips the count read; a word end reports from the count
//   state (walk if broken off, at once if aborted), then the next waits for idle
// reset: after reset a clearing pass writes zero to every node row,
//   NODE_COUNT rows (1024), with req_tready low
// stalls: a result waits in the output register; the input stays closed until
//   that register is empty or emptied in the same cycle
`default_nettype none

module counting_prefix_trie (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [4:0] letter, [7:5] zero
   input  wire logic [2:0]  req_tuser,   // [1:0] command, [2] has_letter
   input  wire logic        req_tlast,   // last_letter
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] count
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   // control state
   cpt_pkg::state_type              state_ff, state_in;
   logic [cpt_pkg::NODE_W-1:0]      clr_ff, clr_in;
   logic [cpt_pkg::NODE_W-1:0]      cur_ff, cur_in;
   logic [cpt_pkg::FREE_W-1:0]      free_ff, free_in;
   cpt_pkg::status_type             abort_ff, abort_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // the item being worked on
   cpt_pkg::cmd_type                cmd_ff, cmd_in;
   logic [cpt_pkg::LETTER_W-1:0]    letter_ff, letter_in;
   logic                            has_ff, has_in;
   logic                            last_ff, last_in;

   // result register
   logic [cpt_pkg::OUT_W-1:0]       rsp_count_ff, rsp_count_in;
   cpt_pkg::status_type             rsp_status_ff, rsp_status_in;

   // child link memory: one row of ALPHABET_SIZE links per node
   logic [cpt_pkg::ROW_W-1:0]       child_mem [cpt_pkg::NODE_COUNT];
   logic                            child_rd_en, child_we;
   logic [cpt_pkg::NODE_W-1:0]      child_rd_addr, child_wr_addr;
   logic [cpt_pkg::ROW_W-1:0]       child_wr_row, child_rd_ff;

   // count memory: end and prefix count per node
   cpt_pkg::count_row_type          cnt_mem [cpt_pkg::NODE_COUNT];
   logic                            cnt_rd_en, cnt_we;
   logic [cpt_pkg::NODE_W-1:0]      cnt_rd_addr, cnt_wr_addr;
   cpt_pkg::count_row_type          cnt_wr_row, cnt_rd_ff;

   // helpers
   logic                            out_free, take, word_end, new_end, is_query, new_query;
   logic [cpt_pkg::LINK_W-1:0]      link;
   cpt_pkg::status_type             fail;
   cpt_pkg::cmd_type                req_cmd;
   logic [cpt_pkg::LETTER_W-1:0]    req_letter;
   logic                            req_has;

   assign req_cmd    = cpt_pkg::cmd_type'(req_tuser[1:0]);
   assign req_has    = req_tuser[2];
   assign req_letter = req_tdata[cpt_pkg::LETTER_W-1:0];

   // output slot is free when empty or being emptied this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign word_end = last_ff || !has_ff;
   assign is_query = (cmd_ff == cpt_pkg::CMD_EQUAL) || (cmd_ff == cpt_pkg::CMD_PREFIX);
   assign new_end  = req_tlast || !req_has;
   assign new_query = (req_cmd == cpt_pkg::CMD_EQUAL) || (req_cmd == cpt_pkg::CMD_PREFIX);

   // accept in idle, or in the count cycle of a letter that ends no word, while the output slot is free
   assign req_tready = out_free &&
                       ((state_ff == cpt_pkg::ST_IDLE) ||
                        ((state_ff == cpt_pkg::ST_COUNT) && !word_end));
   assign take = req_tvalid && req_tready;

   // link selected by the current letter from the row just read
   assign link = child_rd_ff[letter_ff * cpt_pkg::LINK_W +: cpt_pkg::LINK_W];

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      free_in       = free_ff;
      abort_in      = abort_ff;
      cmd_in        = cmd_ff;
      letter_in     = letter_ff;
      has_in        = has_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      child_rd_en   = 1'b0;
      child_rd_addr = cur_ff;
      child_we      = 1'b0;
      child_wr_addr = cur_ff;
      child_wr_row  = child_rd_ff;
      cnt_rd_en     = 1'b0;
      cnt_rd_addr   = cur_ff;
      cnt_we        = 1'b0;
      cnt_wr_addr   = cur_ff;
      cnt_wr_row    = cnt_rd_ff;
      fail          = cpt_pkg::STATUS_OK;

      unique case (state_ff)
         cpt_pkg::ST_CLEAR: begin
            // zero one node row per cycle
            child_we      = 1'b1;
            child_wr_addr = clr_ff;
            child_wr_row  = '0;
            cnt_we        = 1'b1;
            cnt_wr_addr   = clr_ff;
            cnt_wr_row    = '0;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == cpt_pkg::NODE_W'(cpt_pkg::NODE_COUNT - 1)) begin
               state_in = cpt_pkg::ST_IDLE;
            end
         end

         cpt_pkg::ST_IDLE: begin
         end

         cpt_pkg::ST_WALK: begin
            if (cmd_ff == cpt_pkg::CMD_INSERT) begin
               if (link == '0) begin
                  if (free_ff >= cpt_pkg::FREE_W'(cpt_pkg::NODE_COUNT)) begin
                     fail = cpt_pkg::STATUS_POOL_FULL;
                  end
               end
            end else if (link == '0) begin
               fail = cpt_pkg::STATUS_NOT_FOUND;
            end

            if (fail != cpt_pkg::STATUS_OK) begin
               if (!last_ff) begin
                  abort_in = fail;
                  state_in = cpt_pkg::ST_IDLE;
               end else if (out_free) begin
                  // word ends on a broken walk
                  rsp_valid_in  = 1'b1;
                  rsp_count_in  = '0;
                  rsp_status_in = is_query ? cpt_pkg::STATUS_OK : fail;
                  cur_in        = '0;
                  abort_in      = cpt_pkg::STATUS_OK;
                  state_in      = cpt_pkg::ST_IDLE;
               end
            end else begin
               cur_in = link;
               if ((cmd_ff == cpt_pkg::CMD_INSERT) && (link == '0)) begin
                  // allocate the next node from the bump counter
                  child_we     = 1'b1;
                  child_wr_row = child_rd_ff;
                  child_wr_row[letter_ff * cpt_pkg::LINK_W +: cpt_pkg::LINK_W] =
                     free_ff[cpt_pkg::NODE_W-1:0];
                  free_in      = free_ff + 1'b1;
                  cur_in       = free_ff[cpt_pkg::NODE_W-1:0];
               end
               if (is_query && !last_ff) begin
                  state_in = cpt_pkg::ST_IDLE;
               end else begin
                  cnt_rd_en   = 1'b1;
                  cnt_rd_addr = cur_in;
                  state_in    = cpt_pkg::ST_COUNT;
               end
            end
         end

         cpt_pkg::ST_COUNT: begin
            if (!word_end || out_free) begin
               cnt_we      = 1'b1;
               cnt_wr_addr = cur_ff;
               cnt_wr_row  = cnt_rd_ff;
               if (has_ff) begin
                  if (cmd_ff == cpt_pkg::CMD_INSERT) begin
                     cnt_wr_row.pfx_cnt = cpt_pkg::sat_inc(cnt_rd_ff.pfx_cnt);
                  end else if (cmd_ff == cpt_pkg::CMD_ERASE) begin
                     cnt_wr_row.pfx_cnt = cpt_pkg::sat_dec(cnt_rd_ff.pfx_cnt);
                  end
               end
               if (word_end) begin
                  if (cmd_ff == cpt_pkg::CMD_INSERT) begin
                     cnt_wr_row.end_cnt = cpt_pkg::sat_inc(cnt_rd_ff.end_cnt);
                  end else if (cmd_ff == cpt_pkg::CMD_ERASE) begin
                     cnt_wr_row.end_cnt = cpt_pkg::sat_dec(cnt_rd_ff.end_cnt);
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = cpt_pkg::STATUS_OK;
                  unique case (cmd_ff)
                     cpt_pkg::CMD_EQUAL:
                        rsp_count_in = cpt_pkg::clip_count(cnt_rd_ff.end_cnt);
                     cpt_pkg::CMD_PREFIX:
                        rsp_count_in = cpt_pkg::clip_count(cnt_rd_ff.pfx_cnt);
                     default:
                        rsp_count_in = '0;
                  endcase
                  cur_in   = '0;
                  abort_in = cpt_pkg::STATUS_OK;
               end
               state_in = cpt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = cpt_pkg::ST_IDLE;
         end
      endcase

      // new transaction starts from the state left by the step above
      if (take) begin
         cmd_in    = req_cmd;
         letter_in = req_letter;
         has_in    = req_has;
         last_in   = req_tlast;
         state_in  = cpt_pkg::ST_IDLE;
         fail      = abort_in;
         if (req_has && (abort_in == cpt_pkg::STATUS_OK) &&
             (32'(req_letter) >= cpt_pkg::ALPHABET_SIZE)) begin
            fail = cpt_pkg::STATUS_NOT_FOUND;
         end

         if (fail != cpt_pkg::STATUS_OK) begin
            // aborted word: letters ignored, word end reports at once
            if (new_end) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = '0;
               rsp_status_in = new_query ? cpt_pkg::STATUS_OK : fail;
               cur_in        = '0;
               abort_in      = cpt_pkg::STATUS_OK;
            end else begin
               abort_in = fail;
            end
         end else if (req_has) begin
            child_rd_en   = 1'b1;
            child_rd_addr = cur_in;
            state_in      = cpt_pkg::ST_WALK;
         end else begin
            // empty end of word: read the counts of the node reached
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = cur_in;
            state_in    = cpt_pkg::ST_COUNT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         free_ff      <= cpt_pkg::FREE_W'(1);
         abort_ff     <= cpt_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         abort_ff     <= abort_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      letter_ff     <= letter_in;
      has_ff        <= has_in;
      last_ff       <= last_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // child link memory, read data held between reads
   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_wr_addr] <= child_wr_row;
      end
      if (child_rd_en) begin
         child_rd_ff <= child_mem[child_rd_addr];
      end
   end

   // count memory, write data forwarded to a read of the same node
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_row;
      end
      if (cnt_rd_en) begin
         cnt_rd_ff <= (cnt_we && (cnt_wr_addr == cnt_rd_addr)) ? cnt_wr_row
                                                               : cnt_mem[cnt_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/core/cpt_checker.sv */
// port-level checks of counting_prefix_trie, bound into that module
// depends on cpt_pkg and counting_prefix_trie_defines.svh
`default_nettype none
`include "counting_prefix_trie_defines.svh"

module cpt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [2:0]  req_tuser,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled result holds
   `CPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // nonzero counts only come from queries, which report ok
   `CPT_ASSERT_NOW(a_count_ok, clock, reset, rsp_tvalid && (rsp_tdata != 16'd0), rsp_tuser == cpt_pkg::STATUS_OK)

   // the clearing pass keeps the input closed right after reset
   `CPT_ASSERT_NEXT(a_clear_busy, clock, 1'b0, reset, !req_tready)

   // a letter inside a word makes no result
   `CPT_ASSERT_NEXT(a_no_mid_rsp, clock, reset, req_tvalid && req_tready && req_tuser[2] && !req_tlast && (!rsp_tvalid || rsp_tready), !rsp_tvalid)

endmodule

bind counting_prefix_trie cpt_checker u_cpt_checker (.*);

`default_nettype wire

/* bench/counting_prefix_trie_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for counting_prefix_trie: sends words one letter per transaction
// and checks every word result against a bench trie or pinned row; depends on cpt_pkg

module counting_prefix_trie_tb;

   // one letter transaction as the block sees it
   typedef struct packed {
      cpt_pkg::cmd_type     cmd;
      logic [4:0]           letter;
      logic                 has_letter;
      logic                 last;
   } letter_item_type;

   // one word result
   typedef struct packed {
      logic [15:0]          count;
      cpt_pkg::status_type  status;
   } word_result_type;

   // directed row; pinned rows carry a typed-in result, the rest use the bench trie
   typedef struct packed {
      cpt_pkg::cmd_type     cmd;
      logic [4:0]           letter;
      logic                 has_letter;
      logic                 last;
      logic                 pinned;
      logic [15:0]          count;
      cpt_pkg::status_type  status;
   } script_row_type;

   localparam int SCRIPT_LEN = 25;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // empty words on an empty trie
      '{cpt_pkg::CMD_EQUAL,  5'd0,  1'b0, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_PREFIX, 5'd0,  1'b0, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_ERASE,  5'd0,  1'b0, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_OK},
      // erase of a missing word
      '{cpt_pkg::CMD_ERASE,  5'd25, 1'b1, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_NOT_FOUND},
      // letter outside the alphabet
      '{cpt_pkg::CMD_INSERT, 5'd31, 1'b1, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_NOT_FOUND},
      '{cpt_pkg::CMD_EQUAL,  5'd31, 1'b1, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_OK},
      // insert "a", then "az"
      '{cpt_pkg::CMD_INSERT, 5'd0,  1'b1, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_INSERT, 5'd25, 1'b1, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_EQUAL,  5'd0,  1'b1, 1'b1, 1'b1, 16'd1, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_PREFIX, 5'd0,  1'b1, 1'b1, 1'b1, 16'd2, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_PREFIX, 5'd0,  1'b1, 1'b0, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_PREFIX, 5'd25, 1'b1, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      // insert of the empty word, last mark low
      '{cpt_pkg::CMD_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_EQUAL,  5'd0,  1'b0, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      // commands mixed inside one word
      '{cpt_pkg::CMD_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_EQUAL,  5'd25, 1'b1, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      // erase down to zero and past it
      '{cpt_pkg::CMD_ERASE,  5'd0,  1'b1, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_ERASE,  5'd0,  1'b1, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      // empty item ends a word mid-way
      '{cpt_pkg::CMD_ERASE,  5'd0,  1'b1, 1'b0, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_ERASE,  5'd0,  1'b0, 1'b0, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      // missing link mid-word, rest of the word ignored
      '{cpt_pkg::CMD_ERASE,  5'd16, 1'b1, 1'b0, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_ERASE,  5'd0,  1'b1, 1'b1, 1'b1, 16'd0, cpt_pkg::STATUS_NOT_FOUND},
      '{cpt_pkg::CMD_PREFIX, 5'd0,  1'b1, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK},
      '{cpt_pkg::CMD_ERASE,  5'd0,  1'b1, 1'b1, 1'b0, 16'd0, cpt_pkg::STATUS_OK}
   };

   localparam int LONG_HOLD_CYCLES = 400;

   // ports of the block, all inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [4:0] letter, [7:5] zero
   logic [2:0]  req_tuser = '0;   // [1:0] command, [2] has_letter
   logic        req_tlast = 1'b0; // last_letter
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] count
   logic [1:0]  rsp_tuser;        // [1:0] status

   // bench copy of the trie
   logic [cpt_pkg::NODE_W-1:0]     link_mem [cpt_pkg::NODE_COUNT*cpt_pkg::ALPHABET_SIZE];
   logic [cpt_pkg::COUNT_BITS-1:0] word_end_mem [cpt_pkg::NODE_COUNT];
   logic [cpt_pkg::COUNT_BITS-1:0] word_pass_mem [cpt_pkg::NODE_COUNT];
   logic [cpt_pkg::FREE_W-1:0]     alloc_next;
   logic [cpt_pkg::NODE_W-1:0]     walk_node;
   cpt_pkg::status_type            walk_abort;

   // word results still owed by the block, oldest first
   word_result_type word_results_due [$];

   int check_failures = 0;
   int items_sent = 0;
   int burst_left = 0;

   // long receiver hold-off, requested by the sender side, served by the receiver
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int pattern_left = 0;

   counting_prefix_trie u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // walk one letter transaction through the bench trie; returns 1 when it ends a word
   function automatic bit trie_apply_item(input letter_item_type it,
                                          output word_result_type res);
      int                         slot;
      logic [cpt_pkg::NODE_W-1:0] child;
      res = '{count: 16'd0, status: cpt_pkg::STATUS_OK};
      if (it.has_letter && walk_abort == cpt_pkg::STATUS_OK) begin
         if (it.letter >= cpt_pkg::ALPHABET_SIZE) begin
            // no link can exist for this letter, not even on insert
            walk_abort = cpt_pkg::STATUS_NOT_FOUND;
         end else begin
            slot  = int'(walk_node) * cpt_pkg::ALPHABET_SIZE + int'(it.letter);
            child = link_mem[slot];
            if (child == '0 && it.cmd == cpt_pkg::CMD_INSERT) begin
               if (alloc_next >= cpt_pkg::NODE_COUNT) begin
                  walk_abort = cpt_pkg::STATUS_POOL_FULL;
               end else begin
                  child          = alloc_next[cpt_pkg::NODE_W-1:0];
                  alloc_next     = alloc_next + 1'b1;
                  link_mem[slot] = child;
               end
            end
            if (walk_abort == cpt_pkg::STATUS_OK) begin
               if (child == '0) begin
                  walk_abort = cpt_pkg::STATUS_NOT_FOUND;
               end else begin
                  walk_node = child;
                  if (it.cmd == cpt_pkg::CMD_INSERT && word_pass_mem[child] != '1)
                     word_pass_mem[child] = word_pass_mem[child] + 1'b1;
                  if (it.cmd == cpt_pkg::CMD_ERASE && word_pass_mem[child] != '0)
                     word_pass_mem[child] = word_pass_mem[child] - 1'b1;
               end
            end
         end
      end
      if (it.has_letter && !it.last)
         return 1'b0;
      // word end: the final command decides what happens at the node reached
      case (it.cmd)
         cpt_pkg::CMD_EQUAL: begin
            if (walk_abort == cpt_pkg::STATUS_OK) res.count = word_end_mem[walk_node];
         end
         cpt_pkg::CMD_PREFIX: begin
            if (walk_abort == cpt_pkg::STATUS_OK) res.count = word_pass_mem[walk_node];
         end
         cpt_pkg::CMD_INSERT: begin
            res.status = walk_abort;
            if (walk_abort == cpt_pkg::STATUS_OK && word_end_mem[walk_node] != '1)
               word_end_mem[walk_node] = word_end_mem[walk_node] + 1'b1;
         end
         default: begin
            res.status = walk_abort;
            if (walk_abort == cpt_pkg::STATUS_OK && word_end_mem[walk_node] != '0)
               word_end_mem[walk_node] = word_end_mem[walk_node] - 1'b1;
         end
      endcase
      walk_node  = '0;
      walk_abort = cpt_pkg::STATUS_OK;
      return 1'b1;
   endfunction

   function automatic cpt_pkg::cmd_type pick_command();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return cpt_pkg::CMD_INSERT;
         4, 5:       return cpt_pkg::CMD_EQUAL;
         6, 7:       return cpt_pkg::CMD_PREFIX;
         default:    return cpt_pkg::CMD_ERASE;
      endcase
   endfunction

   // offer one transaction, hold it until taken, then predict and pace the next one
   task automatic send_letter_item(input letter_item_type it, input bit pinned,
                                   input word_result_type pinned_res);
      word_result_type res;
      int              gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, it.letter};
      req_tuser  <= {it.has_letter, it.cmd};
      req_tlast  <= it.last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      items_sent++;
      if (trie_apply_item(it, res))
         word_results_due.push_back(pinned ? pinned_res : res);
      // bursts of random length, random gaps between them
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // one word; noisy words may carry bad letters, mixed commands or an empty-item end
   task automatic send_word(input int len, input int letter_hi, input cpt_pkg::cmd_type cmd,
                            input bit noisy);
      letter_item_type it;
      word_result_type none;
      bit              open_end;
      none     = '{count: 16'd0, status: cpt_pkg::STATUS_OK};
      open_end = noisy && ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
         it.cmd        = cmd;
         it.letter     = 5'($urandom_range(0, letter_hi));
         it.has_letter = 1'b1;
         it.last       = (i == len - 1) && !open_end;
         if (noisy && $urandom_range(0, 7) == 0) it.letter = 5'($urandom_range(0, 31));
         if (noisy && $urandom_range(0, 7) == 0)
            it.cmd = cpt_pkg::cmd_type'($urandom_range(0, 3));
         send_letter_item(it, 1'b0, none);
      end
      if (len == 0 || open_end) begin
         it.cmd        = (len == 0) ? cmd : cpt_pkg::cmd_type'($urandom_range(0, 3));
         it.letter     = 5'($urandom_range(0, 31));
         it.has_letter = 1'b0;
         it.last       = 1'($urandom_range(0, 1));
         send_letter_item(it, 1'b0, none);
      end
   endtask

   // stop offering and wait until every owed result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (word_results_due.size() != 0);
   endtask

   // receiver: ready and stall runs of its own, plus the long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (pattern_left > 0) begin
         pattern_left <= pattern_left - 1;
      end else if (rsp_tready) begin
         rsp_tready   <= 1'b0;
         pattern_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready   <= 1'b1;
         pattern_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
      end
   end

   // result checker: every accepted result against the oldest owed one
   always @(posedge clock) begin
      word_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (word_results_due.size() == 0) begin
            $error("unexpected result: count %0d, status %0d", rsp_tdata, rsp_tuser);
            check_failures++;
         end else begin
            want = word_results_due.pop_front();
            if (rsp_tdata !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_tdata);
               check_failures++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               check_failures++;
            end
         end
      end
   end

   // stimulus
   initial begin
      letter_item_type it;
      word_result_type pin;
      int              phase_end;
      foreach (link_mem[i]) link_mem[i] = '0;
      foreach (word_end_mem[i]) begin
         word_end_mem[i]  = '0;
         word_pass_mem[i] = '0;
      end
      alloc_next = cpt_pkg::FREE_W'(1);
      walk_node  = '0;
      walk_abort = cpt_pkg::STATUS_OK;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part; the block clears its pool first, the handshake waits it out
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         it.cmd        = SCRIPT[r].cmd;
         it.letter     = SCRIPT[r].letter;
         it.has_letter = SCRIPT[r].has_letter;
         it.last       = SCRIPT[r].last;
         pin.count     = SCRIPT[r].count;
         pin.status    = SCRIPT[r].status;
         send_letter_item(it, SCRIPT[r].pinned, pin);
      end

      // short words over a few letters so that queries and erases find paths
      while (items_sent < 300)
         send_word(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5), 3,
                   pick_command(), $urandom_range(0, 4) == 0);
      // long receiver hold while the sender keeps offering
      hold_requests <= hold_requests + 1;
      while (items_sent < 600)
         send_word(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5), 3,
                   pick_command(), $urandom_range(0, 4) == 0);
      drain_results();

      // long words over the whole alphabet until the node pool runs out
      while (alloc_next < cpt_pkg::NODE_COUNT)
         send_word($urandom_range(4, 12), 25,
                   ($urandom_range(0, 4) == 0) ? pick_command() : cpt_pkg::CMD_INSERT,
                   1'b0);

      // full pool: old paths still work, new ones report pool full
      phase_end = items_sent + 300;
      while (items_sent < phase_end) begin
         if ($urandom_range(0, 3) == 0)
            send_word($urandom_range(1, 8), 25, cpt_pkg::CMD_INSERT, 1'b0);
         else
            send_word(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5), 3,
                      pick_command(), $urandom_range(0, 4) == 0);
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (check_failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
